// ----- sv/bumper_escape_sequencer_assert.svh -----
// Assertion macros shared by the bumper escape sequencer modules.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef BUMPER_ESCAPE_SEQUENCER_ASSERT_SVH
`define BUMPER_ESCAPE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, skipped while reset is held
`define BES_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is held
`define BES_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bes_pkg.sv -----
// Types and constants of the bumper escape sequencer.
// No dependencies; used by the interfaces, the divider and the top level.
package bes_pkg;

  localparam int DIR_W   = 3;
  localparam int VEL_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUO_W   = 15;

  // Bump direction codes
  typedef logic [DIR_W-1:0] dir_t;
  localparam dir_t DIR_NONE        = 3'd0;
  localparam dir_t DIR_FRONT       = 3'd1;
  localparam dir_t DIR_FRONT_LEFT  = 3'd2;
  localparam dir_t DIR_FRONT_RIGHT = 3'd3;
  localparam dir_t DIR_REAR        = 3'd4;
  localparam dir_t DIR_REAR_LEFT   = 3'd5;
  localparam dir_t DIR_REAR_RIGHT  = 3'd6;
  localparam dir_t DIR_SPARE       = 3'd7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKUP_TICKS,
    CFG_TURN_TICKS,
    CFG_ESC_SPEED,
    CFG_TURN_GAIN,
    CFG_CENTER_WEIGHT,
    CFG_SIDE_WEIGHT,
    CFG_DRAIN,
    CFG_FIRST_MULT
  } cfg_idx_t;

  // Register reset values
  localparam logic [7:0]  RST_BACKUP_TICKS  = 8'd5;
  localparam logic [7:0]  RST_TURN_TICKS    = 8'd10;
  localparam logic [14:0] RST_ESC_SPEED     = 15'd100;
  localparam logic [15:0] RST_TURN_GAIN     = 16'd1000;
  localparam logic [15:0] RST_CENTER_WEIGHT = 16'd20000;
  localparam logic [15:0] RST_SIDE_WEIGHT   = 16'd10000;
  localparam logic [15:0] RST_DRAIN         = 16'd320;
  localparam logic [3:0]  RST_FIRST_MULT    = 4'd4;

  localparam logic [QUO_W-1:0] TURN_MAX = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } seq_state_t;

  // Divider states
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_MUL,
    DV_CHK,
    DV_STEP
  } div_state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/bes_if.sv -----
// Channel interfaces of the bumper escape sequencer: input, result, config.
// Depends on bes_pkg for field widths.
interface bes_in_if;
  import bes_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [DIR_W-1:0]        bump_dir;
  logic                    random_bit;
  logic signed [VEL_W-1:0] wander_linear;
  logic signed [VEL_W-1:0] wander_angular;

  modport source (output valid, bump_dir, random_bit, wander_linear, wander_angular,
                  input ready);
  modport sink (input valid, bump_dir, random_bit, wander_linear, wander_angular,
                output ready);
endinterface

interface bes_out_if;
  import bes_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] linear_out;
  logic signed [VEL_W-1:0] angular_out;
  logic                    escaping;

  modport source (output valid, linear_out, angular_out, escaping, input ready);
  modport sink (input valid, linear_out, angular_out, escaping, output ready);
endinterface

interface bes_cfg_if;
  import bes_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/bumper_escape_sequencer.sv -----
// Bumper escape sequencer: each tick's result is registered, then loaded into the output stage.
// A tick that ends a backing phase first waits for the turn-rate unit (multiply, check,
// 15 divide steps), which stops early when the turn rate saturates. A new tick is taken
// only after the previous result has gone to the output stage. Synchronous active-low reset
// restores register defaults, clears all escape state, the bucket and the output valid flag.
// Depends on bes_pkg, bes_if, bes_div and bumper_escape_sequencer_assert.svh.
`include "bumper_escape_sequencer_assert.svh"

module bumper_escape_sequencer #(
  parameter int BUCKET_BITS = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  bes_in_if.sink    in_ch,
  bes_out_if.source out_ch,
  bes_cfg_if.sink   cfg_ch
);
  import bes_pkg::*;

  localparam int SUM_W = ((BUCKET_BITS > 20) ? BUCKET_BITS : 20) + 1;

  // Configuration registers
  logic [7:0]  backup_ticks_r;
  logic [7:0]  turn_ticks_r;
  logic [14:0] esc_speed_r;
  logic [15:0] turn_gain_r;
  logic [15:0] center_weight_r;
  logic [15:0] side_weight_r;
  logic [15:0] drain_r;
  logic [3:0]  first_mult_r;

  // Escape state
  dir_t                   prev_dir_r, prev_dir_nxt;
  logic [7:0]             backup_r, backup_nxt;
  logic [7:0]             turn_r, turn_nxt;
  logic [QUO_W-1:0]       turn_rate_r;
  logic [BUCKET_BITS-1:0] bucket_r, bucket_nxt;
  logic [BUCKET_BITS-1:0] resp_r, resp_nxt;
  logic                   hif_r, hif_nxt;
  logic                   ttl_r, ttl_nxt;

  // Sequencer and result stage
  seq_state_t         state_r, state_nxt;
  logic [VEL_W-1:0]   res_lin_r, res_lin_nxt;
  logic [VEL_W-1:0]   res_ang_r, res_ang_nxt;
  logic               res_esc_r, res_esc_nxt;
  logic               out_valid_r;
  logic [VEL_W-1:0]   out_lin_r;
  logic [VEL_W-1:0]   out_ang_r;
  logic               out_esc_r;

  logic               in_xfer;
  logic               load_out;
  logic               start_div;
  div_stat_t          div_stat;
  logic [QUO_W-1:0]   div_quo;

  // Configuration: always ready, one register per transfer
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backup_ticks_r  <= RST_BACKUP_TICKS;
      turn_ticks_r    <= RST_TURN_TICKS;
      esc_speed_r     <= RST_ESC_SPEED;
      turn_gain_r     <= RST_TURN_GAIN;
      center_weight_r <= RST_CENTER_WEIGHT;
      side_weight_r   <= RST_SIDE_WEIGHT;
      drain_r         <= RST_DRAIN;
      first_mult_r    <= RST_FIRST_MULT;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_BACKUP_TICKS:  backup_ticks_r  <= cfg_ch.data[7:0];
        CFG_TURN_TICKS:    turn_ticks_r    <= cfg_ch.data[7:0];
        CFG_ESC_SPEED:     esc_speed_r     <= cfg_ch.data[14:0];
        CFG_TURN_GAIN:     turn_gain_r     <= cfg_ch.data;
        CFG_CENTER_WEIGHT: center_weight_r <= cfg_ch.data;
        CFG_SIDE_WEIGHT:   side_weight_r   <= cfg_ch.data;
        CFG_DRAIN:         drain_r         <= cfg_ch.data;
        CFG_FIRST_MULT:    first_mult_r    <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  // Tick update: bump detection, bucket feed, phase counters, drain
  always_comb begin
    dir_t                   dir;
    logic                   fresh_hit;
    logic                   centre;
    logic                   is_left;
    logic                   known_dir;
    logic [15:0]            weight;
    logic [19:0]            first_w;
    logic [SUM_W-1:0]       sum;
    logic [BUCKET_BITS-1:0] sat;
    logic [BUCKET_BITS-1:0] bucket_mid;
    logic [VEL_W-1:0]       lin_mag;
    logic [VEL_W-1:0]       lin_esc;
    logic [VEL_W-1:0]       rate_mag;

    dir       = in_ch.bump_dir;
    fresh_hit = (dir != DIR_NONE) && (dir != prev_dir_r);
    centre    = (dir == DIR_FRONT) || (dir == DIR_REAR);
    is_left   = (dir == DIR_FRONT_LEFT) || (dir == DIR_REAR_LEFT);
    known_dir = (dir != DIR_NONE) && (dir != DIR_SPARE);
    weight    = centre ? center_weight_r : side_weight_r;
    first_w   = 20'(first_mult_r) * 20'(weight);

    if (bucket_r == '0) begin
      sum = SUM_W'(first_w);
    end else begin
      sum = SUM_W'(bucket_r) + SUM_W'(weight);
    end
    sat = (sum[SUM_W-1:BUCKET_BITS] != '0) ? '1 : sum[BUCKET_BITS-1:0];

    prev_dir_nxt = dir;
    backup_nxt   = backup_r;
    turn_nxt     = turn_r;
    bucket_mid   = bucket_r;
    resp_nxt     = resp_r;
    hif_nxt      = hif_r;
    ttl_nxt      = ttl_r;
    start_div    = 1'b0;

    // Start an escape on a new bump
    if (fresh_hit) begin
      backup_nxt = backup_ticks_r;
      if (known_dir) begin
        hif_nxt = (dir < DIR_REAR);
        if (bucket_r == '0) begin
          ttl_nxt  = centre ? in_ch.random_bit : is_left;
          resp_nxt = sat;
        end else begin
          resp_nxt = bucket_r;
        end
        bucket_mid = sat;
      end
    end

    lin_mag  = {1'b0, esc_speed_r};
    lin_esc  = hif_nxt ? (VEL_W'(0) - lin_mag) : lin_mag;
    rate_mag = {1'b0, turn_rate_r};

    // Backing phase first, then turning phase, else pass the wander command
    res_esc_nxt = 1'b0;
    res_lin_nxt = in_ch.wander_linear;
    res_ang_nxt = in_ch.wander_angular;
    if (backup_nxt != '0) begin
      res_esc_nxt = 1'b1;
      res_lin_nxt = lin_esc;
      res_ang_nxt = '0;
      backup_nxt  = backup_nxt - 8'd1;
      if (backup_nxt == '0) begin
        turn_nxt  = turn_ticks_r;
        start_div = 1'b1;
      end
    end else if (turn_r != '0) begin
      res_esc_nxt = 1'b1;
      res_lin_nxt = lin_esc;
      res_ang_nxt = ttl_nxt ? (VEL_W'(0) - rate_mag) : rate_mag;
      turn_nxt    = turn_r - 8'd1;
    end

    // Leak the bucket, floored at zero
    if (bucket_mid > BUCKET_BITS'(drain_r)) begin
      bucket_nxt = bucket_mid - BUCKET_BITS'(drain_r);
    end else begin
      bucket_nxt = '0;
    end
  end

  assign in_xfer = in_ch.valid && in_ch.ready;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state and handshake
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = start_div ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Escape state: advance on each input transfer; the turn rate loads when the divider is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_dir_r  <= DIR_NONE;
      backup_r    <= '0;
      turn_r      <= '0;
      turn_rate_r <= '0;
      bucket_r    <= '0;
      resp_r      <= '0;
      hif_r       <= 1'b0;
      ttl_r       <= 1'b0;
    end else begin
      if (in_xfer) begin
        prev_dir_r <= prev_dir_nxt;
        backup_r   <= backup_nxt;
        turn_r     <= turn_nxt;
        bucket_r   <= bucket_nxt;
        resp_r     <= resp_nxt;
        hif_r      <= hif_nxt;
        ttl_r      <= ttl_nxt;
      end
      if (div_stat.done) begin
        turn_rate_r <= div_quo;
      end
    end
  end

  // Hold the tick result until the output stage is free
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_lin_r <= res_lin_nxt;
      res_ang_r <= res_ang_nxt;
      res_esc_r <= res_esc_nxt;
    end
    if (load_out) begin
      out_lin_r <= res_lin_r;
      out_ang_r <= res_ang_r;
      out_esc_r <= res_esc_r;
    end
  end

  // Output valid: set on load, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.linear_out  = out_lin_r;
  assign out_ch.angular_out = out_ang_r;
  assign out_ch.escaping    = out_esc_r;

  // Turn-rate unit
  bes_div #(
    .BUCKET_BITS(BUCKET_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_xfer && start_div),
    .mul_a   (turn_gain_r),
    .mul_b   (resp_nxt),
    .divisor (center_weight_r),
    .stat    (div_stat),
    .quo     (div_quo)
  );

  `BES_ASSERT_IMP(a_done_in_div, div_stat.done, state_r == ST_DIV,
                  "turn rate finished outside the divide wait")
  `BES_ASSERT_IMP(a_idle_div_free, state_r == ST_IDLE, !div_stat.busy,
                  "divider busy while sequencer idle")
  `BES_ASSERT_NXT(a_emit_loads, (state_r == ST_EMIT) && !out_valid_r, out_valid_r,
                  "free output stage not loaded")

endmodule

// ----- sv/bes_div.sv -----
// Shared multiply and restoring-divide unit for the escape turn rate.
// Depends on bes_pkg and bumper_escape_sequencer_assert.svh.
`include "bumper_escape_sequencer_assert.svh"

module bes_div #(
  parameter int BUCKET_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [15:0]                  mul_a,
  input  logic [BUCKET_BITS-1:0]       mul_b,
  input  logic [15:0]                  divisor,
  output bes_pkg::div_stat_t           stat,
  output logic [bes_pkg::QUO_W-1:0]    quo
);
  import bes_pkg::*;

  localparam int PW = 16 + BUCKET_BITS;
  localparam int HW = PW - QUO_W;

  div_state_t state_r, state_nxt;
  logic       done_r, done_nxt;

  logic [15:0]            a_r;
  logic [BUCKET_BITS-1:0] b_r;
  logic [15:0]            cw_r;
  logic [PW-1:0]          prod_r;
  logic [QUO_W-1:0]       low_r;
  logic [15:0]            rem_r;
  logic [QUO_W-1:0]       quo_r;
  logic [3:0]             cnt_r;

  logic        ovf;
  logic [16:0] trial;
  logic        ge;

  // Overflow: quotient would exceed the turn limit (also covers a zero divisor)
  assign ovf   = prod_r[PW-1:QUO_W] >= HW'(cw_r);
  assign trial = {rem_r, low_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, cw_r};

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      DV_IDLE: begin
        if (start) begin
          state_nxt = DV_MUL;
        end
      end
      DV_MUL: begin
        state_nxt = DV_CHK;
      end
      DV_CHK: begin
        if (ovf) begin
          state_nxt = DV_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = DV_STEP;
        end
      end
      DV_STEP: begin
        if (cnt_r == '0) begin
          state_nxt = DV_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  // Datapath: capture operands, multiply once, then one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && start) begin
      a_r  <= mul_a;
      b_r  <= mul_b;
      cw_r <= divisor;
    end
    if (state_r == DV_MUL) begin
      prod_r <= PW'(a_r) * PW'(b_r);
    end
    if (state_r == DV_CHK) begin
      low_r <= prod_r[QUO_W-1:0];
      rem_r <= prod_r[QUO_W +: 16];
      cnt_r <= 4'(QUO_W - 1);
      if (ovf) begin
        quo_r <= TURN_MAX;
      end
    end
    if (state_r == DV_STEP) begin
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      rem_r <= ge ? 16'(trial - {1'b0, cw_r}) : trial[15:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      cnt_r <= cnt_r - 4'd1;
    end
  end

  assign stat.busy = (state_r != DV_IDLE);
  assign stat.done = done_r;
  assign quo       = quo_r;

  `BES_ASSERT_NXT(a_div_start, (state_r == DV_IDLE) && start, state_r == DV_MUL,
                  "divider did not start on request")
  `BES_ASSERT_IMP(a_div_rem, state_r == DV_STEP, rem_r < cw_r,
                  "partial remainder not below divisor")
  `BES_ASSERT_IMP(a_div_done, done_r, state_r == DV_IDLE,
                  "divider done while still busy")

endmodule
